// ===== design/kvsd_pkg.sv =====
package kvsd_pkg;

  // stream parse positions
  localparam logic [3:0] IDX_COUNT = 4'd0;
  localparam logic [3:0] IDX_FLAG  = 4'd1;
  localparam logic [3:0] IDX_PARTS = 4'd2;
  localparam logic [3:0] IDX_MAX   = 4'd9;

  localparam logic [5:0] BONE_END  = 6'h3f;
  localparam int unsigned FLAG_ROT   = 7;
  localparam int unsigned FLAG_BYTES = 6;

  // rate scaling: position rate * 32, rotation rate * 8
  localparam int unsigned POS_SHIFT = 5;
  localparam int unsigned ROT_SHIFT = 3;
  localparam int unsigned LOAD_SHIFT = 8;

  // pipeline operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_REC  = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [5:0]         load_bone;
    logic signed [15:0] init_pos_x;
    logic signed [15:0] init_pos_y;
    logic signed [15:0] init_pos_z;
    logic signed [15:0] init_rot_w;
    logic signed [15:0] init_rot_x;
    logic signed [15:0] init_rot_y;
    logic signed [15:0] init_rot_z;
    logic [7:0]         data_byte;
    logic               stream_last;
  } kvsd_in_t;

  typedef struct packed {
    logic [5:0]         bone;
    logic [23:0]        frame;
    logic               is_rotation;
    logic signed [47:0] value_a;
    logic signed [47:0] value_b;
    logic signed [47:0] value_c;
    logic signed [47:0] value_d;
    logic signed [15:0] rate_a;
    logic signed [15:0] rate_b;
    logic signed [15:0] rate_c;
    logic signed [15:0] rate_d;
    logic               end_of_stream;
  } kvsd_out_t;

endpackage

// ===== design/kvsd_in_if.sv =====
interface kvsd_in_if import kvsd_pkg::*; ();
  logic     valid;
  logic     ready;
  kvsd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/kvsd_out_if.sv =====
interface kvsd_out_if import kvsd_pkg::*; ();
  logic      valid;
  logic      ready;
  kvsd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/keyframe_velocity_stream_decoder.sv =====
// channel | dir | beat contents
// in_i    | in  | load pose of one bone, or one stream byte (+ last flag)
// out_o   | out | one decoded record or end-of-stream marker
//
// One beat per cycle in, sustained while the output is not stalled; the result of the
// completing byte passes parse/read, multiply, saturate/write-back + output reg.
// The bone table is one synchronous memory, one full-entry read-modify-write
// per beat; forwarding from the write-back stage and the last write covers
// back-to-back hits on the same bone.
// Reset clears the parser and pipeline valids; table contents stay undefined
// until a load writes them. A stalled output freezes the whole pipeline.
module keyframe_velocity_stream_decoder import kvsd_pkg::*; #(
  parameter int unsigned BONE_SLOTS = 64,
  parameter int unsigned FRAME_BITS = 24,
  parameter int unsigned VALUE_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  kvsd_in_if.sink         in_i,
  kvsd_out_if.source      out_o
);

  localparam int unsigned AW = (BONE_SLOTS > 1) ? $clog2(BONE_SLOTS) : 1;
  localparam int unsigned FB = FRAME_BITS;
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned PW = FB + 17;          // rate * elapsed
  localparam int unsigned SW = VB + PW + 6;      // saturating sum width
  localparam logic signed [SW-1:0] VMAX_W = (SW'(1) <<< (VB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VMIN_W = -VMAX_W - SW'(1);
  localparam logic [FB-1:0] FMAX = '1;

  // value slots 0..2 position x,y,z; 3..6 rotation w,x,y,z.
  // rate slots  0..2 velocity;       3..6 angular rate.
  typedef struct packed {
    logic [6:0][VB-1:0] val;
    logic [6:0][15:0]   rate;
    logic [FB-1:0]      vel_frame;
    logic [FB-1:0]      ang_frame;
  } entry_t;

  logic advance, accept;
  assign advance = !out_o.valid || out_o.ready;
  assign accept  = in_i.valid && advance;
  assign in_i.ready = advance;

  // ---------------- stream parser ----------------
  logic [FB-1:0] fc_q, fc_d;
  logic [3:0]    idx_q, idx_d;
  logic [15:0]   hdr_q, hdr_d;
  logic [63:0]   pb_q, pb_d, pb_new;
  logic [2:0]    pos;
  logic [7:0]    flag, byte_in;
  logic          rot, bytes_fmt;
  logic [3:0]    need;
  logic [FB:0]   fc_sum;
  logic [FB-1:0] fc_sat;
  logic          em_rec, em_end, em_eos;
  logic [3:0][15:0] parts;

  assign byte_in   = in_i.data.data_byte;
  assign flag      = hdr_q[15:8];
  assign rot       = flag[FLAG_ROT];
  assign bytes_fmt = flag[FLAG_BYTES];
  assign need      = bytes_fmt ? (rot ? 4'd4 : 4'd3) : (rot ? 4'd8 : 4'd6);
  assign pos       = 3'(idx_q - IDX_PARTS);
  assign pb_new    = pb_q | (64'(byte_in) << {pos, 3'b000});
  assign fc_sum    = {1'b0, fc_q} + (FB+1)'(hdr_q[7:0]);
  assign fc_sat    = fc_sum[FB] ? FMAX : fc_sum[FB-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (bytes_fmt) begin
        parts[i] = {{8{pb_new[8*i+7]}}, pb_new[8*i +: 8]};
      end else begin
        parts[i] = pb_new[16*i +: 16];
      end
      if (i == 3 && !rot) begin
        parts[i] = '0;
      end
    end
  end

  always_comb begin
    idx_d  = idx_q;
    hdr_d  = hdr_q;
    pb_d   = pb_q;
    fc_d   = fc_q;
    em_rec = 1'b0;
    em_end = 1'b0;
    em_eos = 1'b0;
    if (accept && in_i.data.kind) begin
      case (idx_q)
        IDX_COUNT: begin
          hdr_d = {8'h00, byte_in};
          idx_d = IDX_FLAG;
          em_end = in_i.data.stream_last;
        end
        IDX_FLAG: begin
          hdr_d[15:8] = byte_in;
          if (byte_in[5:0] == BONE_END) begin
            em_end = 1'b1;
          end else begin
            idx_d  = IDX_PARTS;
            pb_d   = '0;
            em_end = in_i.data.stream_last;
          end
        end
        default: begin
          pb_d  = pb_new;
          idx_d = idx_q + 4'd1;
          if (({1'b0, pos} + 4'd1) >= need) begin
            em_rec = 1'b1;
            idx_d  = IDX_COUNT;
            hdr_d  = '0;
            pb_d   = '0;
            fc_d   = fc_sat;
            if (in_i.data.stream_last) begin
              em_eos = 1'b1;
              fc_d   = '0;
            end
          end else begin
            em_end = in_i.data.stream_last;
          end
        end
      endcase
      if (em_end) begin
        idx_d = IDX_COUNT;
        hdr_d = '0;
        pb_d  = '0;
        fc_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= '0;
      idx_q <= IDX_COUNT;
      hdr_q <= '0;
      pb_q  <= '0;
    end else begin
      fc_q  <= fc_d;
      idx_q <= idx_d;
      hdr_q <= hdr_d;
      pb_q  <= pb_d;
    end
  end

  // ---------------- bone memory ----------------
  entry_t mem [BONE_SLOTS];
  entry_t rdata_q, wr_q, p2_new;
  logic [AW-1:0] rd_addr, wr_addr_q;
  logic          wr_v_q;
  logic [5:0]    bone_in;

  assign bone_in = in_i.data.kind ? flag[5:0] : in_i.data.load_bone;
  assign rd_addr = bone_in[AW-1:0];

  // ---------------- stage 1: forward, multiply ----------------
  logic             p1_v_q;
  logic [1:0]       p1_op_q;
  logic [5:0]       p1_bone_q;
  logic [FB-1:0]    p1_frame_q;
  logic             p1_rot_q, p1_eos_q;
  logic [3:0][15:0] p1_parts_q;
  logic [6:0][15:0] p1_raw_q;

  logic             p2_v_q;
  logic [1:0]       p2_op_q;
  logic [5:0]       p2_bone_q;
  logic [FB-1:0]    p2_frame_q;
  logic             p2_rot_q, p2_eos_q, p2_wen_q;
  logic [AW-1:0]    p2_addr_q;
  logic [3:0][15:0] p2_parts_q;
  entry_t           p2_ent_q, p2_ent_d, cur, ld_ent;
  logic signed [PW-1:0] prod_q [4];
  logic signed [PW-1:0] prod_d [4];

  logic          p1_wen;
  logic [AW-1:0] p1_addr;
  logic [FB-1:0] setf;
  logic signed [FB:0] el;
  logic [15:0]   rate_l [4];

  assign p1_addr = p1_bone_q[AW-1:0];
  assign p1_wen  = (p1_op_q != OP_END) && ({1'b0, p1_bone_q} < 7'(BONE_SLOTS));

  always_comb begin
    if (p2_v_q && p2_wen_q && p2_addr_q == p1_addr) begin
      cur = p2_new;
    end else if (wr_v_q && wr_addr_q == p1_addr) begin
      cur = wr_q;
    end else begin
      cur = rdata_q;
    end
    ld_ent = '0;
    for (int k = 0; k < 7; k++) begin
      ld_ent.val[k] = VB'($signed(p1_raw_q[k])) <<< LOAD_SHIFT;
    end
    setf = p1_rot_q ? cur.ang_frame : cur.vel_frame;
    el   = $signed({1'b0, p1_frame_q}) - $signed({1'b0, setf});
    for (int i = 0; i < 4; i++) begin
      if (p1_rot_q) begin
        rate_l[i] = cur.rate[3+i];
      end else if (i < 3) begin
        rate_l[i] = cur.rate[i];
      end else begin
        rate_l[i] = '0;
      end
      prod_d[i] = $signed(rate_l[i]) * el;
    end
    p2_ent_d = (p1_op_q == OP_LOAD) ? ld_ent : cur;
  end

  // ---------------- stage 2: saturate, write back ----------------
  logic signed [SW-1:0] sum [4];
  logic signed [VB-1:0] sat [4];
  logic [2:0] slot [4];

  always_comb begin
    p2_new = p2_ent_q;
    for (int i = 0; i < 4; i++) begin
      slot[i] = p2_rot_q ? 3'(3 + i) : 3'(i);
      sum[i]  = SW'($signed(p2_ent_q.val[slot[i]]))
              + (SW'(prod_q[i]) <<< (p2_rot_q ? ROT_SHIFT : POS_SHIFT));
      if (sum[i] > VMAX_W) begin
        sat[i] = VB'(VMAX_W);
      end else if (sum[i] < VMIN_W) begin
        sat[i] = VB'(VMIN_W);
      end else begin
        sat[i] = VB'(sum[i]);
      end
      if (!p2_rot_q && i == 3) begin
        sat[i] = '0;
      end
      if (p2_op_q == OP_REC && (p2_rot_q || i < 3)) begin
        p2_new.val[slot[i]]  = sat[i];
        p2_new.rate[slot[i]] = p2_parts_q[i];
      end
    end
    if (p2_op_q == OP_REC) begin
      if (p2_rot_q) begin
        p2_new.ang_frame = p2_frame_q;
      end else begin
        p2_new.vel_frame = p2_frame_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= mem[rd_addr];
      if (p2_v_q && p2_wen_q) begin
        mem[p2_addr_q] <= p2_new;
        wr_q           <= p2_new;
        wr_addr_q      <= p2_addr_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_op_q    <= em_end ? OP_END : (in_i.data.kind ? OP_REC : OP_LOAD);
      p1_bone_q  <= em_end ? BONE_END : bone_in;
      p1_frame_q <= em_end ? fc_q : fc_sat;
      p1_rot_q   <= em_end ? 1'b0 : rot;
      p1_eos_q   <= em_end | em_eos;
      p1_parts_q <= em_end ? '0 : parts;
      p1_raw_q   <= {in_i.data.init_rot_z, in_i.data.init_rot_y, in_i.data.init_rot_x,
                     in_i.data.init_rot_w, in_i.data.init_pos_z, in_i.data.init_pos_y,
                     in_i.data.init_pos_x};
      p2_op_q    <= p1_op_q;
      p2_bone_q  <= p1_bone_q;
      p2_frame_q <= p1_frame_q;
      p2_rot_q   <= p1_rot_q;
      p2_eos_q   <= p1_eos_q;
      p2_parts_q <= p1_parts_q;
      p2_wen_q   <= p1_wen;
      p2_addr_q  <= p1_addr;
      p2_ent_q   <= p2_ent_d;
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  // ---------------- output register ----------------
  kvsd_out_t out_q;
  logic      out_v_q;
  logic [31:0] f32;
  logic [3:0][47:0] vout;

  assign f32 = 32'(p2_frame_q);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vout[i] = (p2_op_q == OP_REC && p2_wen_q) ? 48'(64'($signed(sat[i]))) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.bone          <= p2_bone_q;
      out_q.frame         <= f32[23:0];
      out_q.is_rotation   <= p2_rot_q;
      out_q.value_a       <= vout[0];
      out_q.value_b       <= vout[1];
      out_q.value_c       <= vout[2];
      out_q.value_d       <= vout[3];
      out_q.rate_a        <= p2_parts_q[0];
      out_q.rate_b        <= p2_parts_q[1];
      out_q.rate_c        <= p2_parts_q[2];
      out_q.rate_d        <= p2_parts_q[3];
      out_q.end_of_stream <= p2_eos_q;
    end
  end

  // valids; loads and mid-record bytes give no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      wr_v_q  <= 1'b0;
    end else if (advance) begin
      p1_v_q  <= accept && (!in_i.data.kind || em_rec || em_end);
      p2_v_q  <= p1_v_q;
      out_v_q <= p2_v_q && (p2_op_q != OP_LOAD);
      if (p2_v_q && p2_wen_q) begin
        wr_v_q <= 1'b1;
      end
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // ---------------- checks ----------------
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_MAX) else $error("record byte index out of range");
  a_end_bone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.bone == BONE_END |-> out_o.data.end_of_stream)
    else $error("end bone without end flag");
  a_pos_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.is_rotation |->
      out_o.data.value_d == '0 && out_o.data.rate_d == '0)
    else $error("position record with fourth lane set");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q && !advance |=> p2_v_q) else $error("stage 2 dropped under stall");

endmodule
